### hdl/velocity_kalman_fusion_defines.svh
// Assertion macros shared by the velocity Kalman fusion RTL
`ifndef VELOCITY_KALMAN_FUSION_DEFINES_SVH
`define VELOCITY_KALMAN_FUSION_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define VKF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define VKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vkf_pkg.sv
// Package with types and constants for the velocity Kalman fusion block
package vkf_pkg;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    CFG_DELTA_TIME     = 2'd0,
    CFG_ACCEL_VARIANCE = 2'd1,
    CFG_ODOM_VARIANCE  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

### hdl/vkf_alu.sv
// Shared saturating fixed-point arithmetic unit: add, subtract, multiply, iterative divide
module vkf_alu #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vkf_pkg::alu_req_t            req_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned NW   = W + FRAC_BITS;
  localparam int unsigned CW   = $clog2(NW + 1);
  localparam int unsigned HW   = (W + 1) / 2;
  localparam int unsigned PW   = 2 * W;

  localparam logic signed [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};

  logic          busy_q, busy_d;
  logic          mul_q, mul_d;
  logic [1:0]    mph_q, mph_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  mb_q, mb_d;
  logic [NW-1:0] num_q, num_d;
  logic [W:0]    rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [W-1:0]  ma_q, ma_d;
  logic [PW-1:0] acc_q, acc_d;
  logic          done_q, done_d;
  logic signed [W-1:0] res_q, res_d;

  logic [W-1:0]  mag_a, mag_b;
  logic signed [W:0] sum_ext;
  logic [W:0]    rem_sh;
  logic [W+HW-1:0] pp;
  logic [PW-1:0] prod_sh;
  logic [PW-1:0] fin_mag;

  function automatic logic signed [W-1:0] sat_mag(input logic neg,
                                                  input logic [PW-1:0] m);
    logic signed [W-1:0] r;
    if (neg) begin
      if (m > {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}}) r = VMin;
      else r = W'(-m[W-1:0]);
    end else begin
      if (m > {{(PW-W+1){1'b0}}, {(W-1){1'b1}}}) r = VMax;
      else r = m[W-1:0];
    end
    return r;
  endfunction

  assign mag_a   = a_i[W-1] ? W'(-a_i) : a_i;
  assign mag_b   = b_i[W-1] ? W'(-b_i) : b_i;
  assign rem_sh  = {rem_q[W-1:0], num_q[NW-1]};
  assign pp      = ma_q * (mph_q[0] ? mb_q[W-1:HW] : mb_q[HW-1:0]);
  assign prod_sh = acc_q >> FRAC_BITS;
  assign fin_mag = {{(PW-NW){1'b0}}, quo_q};

  always_comb begin
    sum_ext = '0;
    busy_d = busy_q; mul_d = mul_q; mph_d = mph_q; cnt_d = cnt_q; neg_d = neg_q;
    mb_d = mb_q; num_d = num_q; rem_d = rem_q; quo_d = quo_q; ma_d = ma_q;
    acc_d = acc_q; done_d = 1'b0; res_d = res_q;
    if (req_i.start) begin
      unique case (req_i.op) inside
        vkf_pkg::OP_ADD, vkf_pkg::OP_SUB: begin
          sum_ext = (req_i.op == vkf_pkg::OP_ADD) ? ({a_i[W-1], a_i} + {b_i[W-1], b_i})
                                                   : ({a_i[W-1], a_i} - {b_i[W-1], b_i});
          if (sum_ext[W] != sum_ext[W-1]) res_d = sum_ext[W] ? VMin : VMax;
          else res_d = sum_ext[W-1:0];
          done_d = 1'b1;
        end
        vkf_pkg::OP_MUL: begin
          busy_d = 1'b1; mul_d = 1'b1; mph_d = '0; ma_d = mag_a; mb_d = mag_b;
          acc_d = '0; neg_d = a_i[W-1] ^ b_i[W-1];
        end
        default: begin
          busy_d = 1'b1; mul_d = 1'b0; cnt_d = CW'(NW);
          num_d = {mag_a, {FRAC_BITS{1'b0}}}; rem_d = '0; quo_d = '0;
          mb_d = mag_b; neg_d = a_i[W-1] ^ b_i[W-1];
        end
      endcase
    end else if (busy_q && mul_q) begin
      if (mph_q == 2'd0) begin
        acc_d = PW'(pp); mph_d = 2'd1;
      end else if (mph_q == 2'd1) begin
        acc_d = acc_q + (PW'(pp) << HW); mph_d = 2'd2;
      end else begin
        res_d = sat_mag(neg_q, prod_sh); busy_d = 1'b0; done_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        num_d = num_q << 1;
        if (rem_sh >= {1'b0, mb_q}) begin
          rem_d = rem_sh - {1'b0, mb_q}; quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh; quo_d = {quo_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        res_d = sat_mag(neg_q, fin_mag); busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; mul_q <= 1'b0; mph_q <= '0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; mul_q <= mul_d; mph_q <= mph_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; mb_q <= mb_d; num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
    ma_q <= ma_d; acc_q <= acc_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/velocity_kalman_fusion.sv
// Top level of the two-axis velocity Kalman filter with a microcoded sequencer
// An odometry transaction is taken and latched. An acceleration
// transaction runs 8 operations, or 59 with a pending measurement, through one
// shared arithmetic unit that adds, subtracts, multiplies and divides. A tick with
// an update is paced by the four divisions and the serial multiplies; a
// singular innovation ends the program at the determinant step. The result
// transaction is held in an output register until taken; the next input is
// taken in the cycle after that.
module velocity_kalman_fusion #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // value_fb, value_lr
  input  logic [2*DATA_WIDTH-1:0]               s_axis_tdata,
  // req_type
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // vel_fb, vel_lr
  output logic [2*DATA_WIDTH-1:0]               m_axis_tdata,
  // fused, singular
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [vkf_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [vkf_pkg::CfgWidth-1:0]          cfg_data_i
);

`include "velocity_kalman_fusion_defines.svh"

  localparam int unsigned W = DATA_WIDTH;
  localparam logic signed [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};

  // register file slots
  localparam int unsigned NR = 32;
  localparam int unsigned RW = 5;
  localparam logic [RW-1:0]
    R_ZERO = 5'd0, R_DT = 5'd1, R_QV = 5'd2, R_R = 5'd3, R_A0 = 5'd4, R_A1 = 5'd5,
    R_V0 = 5'd6, R_V1 = 5'd7, R_P0 = 5'd8, R_P1 = 5'd9, R_P2 = 5'd10, R_P3 = 5'd11,
    R_Z0 = 5'd12, R_Z1 = 5'd13, R_T0 = 5'd14, R_Q = 5'd15, R_S0 = 5'd16, R_S3 = 5'd17,
    R_T1 = 5'd18, R_DET = 5'd19, R_I0 = 5'd20, R_I1 = 5'd21, R_I2 = 5'd22,
    R_I3 = 5'd23, R_K0 = 5'd24, R_K1 = 5'd25, R_K2 = 5'd26, R_K3 = 5'd27,
    R_Y0 = 5'd28, R_Y1 = 5'd29, R_N0 = 5'd30, R_N1 = 5'd31;

  typedef struct packed {
    vkf_pkg::alu_op_e op;
    logic [RW-1:0]    a;
    logic [RW-1:0]    b;
    logic [RW-1:0]    dst;
  } uop_t;

  localparam int unsigned PredLen  = 7;
  localparam int unsigned ProgLen  = 58;
  localparam int unsigned PcW      = 6;
  localparam int unsigned DetPc    = 12;

  function automatic uop_t u(input vkf_pkg::alu_op_e op, input logic [RW-1:0] a,
                             input logic [RW-1:0] b, input logic [RW-1:0] d);
    uop_t x;
    x.op = op; x.a = a; x.b = b; x.dst = d;
    return x;
  endfunction

  function automatic uop_t prog(input logic [PcW-1:0] pc);
    uop_t x;
    x = u(vkf_pkg::OP_ADD, R_ZERO, R_ZERO, R_ZERO);
    case (pc)
      6'd0:  x = u(vkf_pkg::OP_MUL, R_DT, R_DT, R_T0);
      6'd1:  x = u(vkf_pkg::OP_MUL, R_T0, R_QV, R_Q);
      6'd2:  x = u(vkf_pkg::OP_MUL, R_DT, R_A0, R_T0);
      6'd3:  x = u(vkf_pkg::OP_ADD, R_V0, R_T0, R_V0);
      6'd4:  x = u(vkf_pkg::OP_MUL, R_DT, R_A1, R_T0);
      6'd5:  x = u(vkf_pkg::OP_ADD, R_V1, R_T0, R_V1);
      6'd6:  x = u(vkf_pkg::OP_ADD, R_P0, R_Q, R_P0);
      6'd7:  x = u(vkf_pkg::OP_ADD, R_P3, R_Q, R_P3);
      6'd8:  x = u(vkf_pkg::OP_ADD, R_P0, R_R, R_S0);
      6'd9:  x = u(vkf_pkg::OP_ADD, R_P3, R_R, R_S3);
      6'd10: x = u(vkf_pkg::OP_MUL, R_S0, R_S3, R_T0);
      6'd11: x = u(vkf_pkg::OP_MUL, R_P1, R_P2, R_T1);
      6'd12: x = u(vkf_pkg::OP_SUB, R_T0, R_T1, R_DET);
      6'd13: x = u(vkf_pkg::OP_DIV, R_S3, R_DET, R_I0);
      6'd14: x = u(vkf_pkg::OP_SUB, R_ZERO, R_P1, R_T0);
      6'd15: x = u(vkf_pkg::OP_DIV, R_T0, R_DET, R_I1);
      6'd16: x = u(vkf_pkg::OP_SUB, R_ZERO, R_P2, R_T0);
      6'd17: x = u(vkf_pkg::OP_DIV, R_T0, R_DET, R_I2);
      6'd18: x = u(vkf_pkg::OP_DIV, R_S0, R_DET, R_I3);
      6'd19: x = u(vkf_pkg::OP_MUL, R_P0, R_I0, R_T0);
      6'd20: x = u(vkf_pkg::OP_MUL, R_P1, R_I2, R_T1);
      6'd21: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_K0);
      6'd22: x = u(vkf_pkg::OP_MUL, R_P0, R_I1, R_T0);
      6'd23: x = u(vkf_pkg::OP_MUL, R_P1, R_I3, R_T1);
      6'd24: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_K1);
      6'd25: x = u(vkf_pkg::OP_MUL, R_P2, R_I0, R_T0);
      6'd26: x = u(vkf_pkg::OP_MUL, R_P3, R_I2, R_T1);
      6'd27: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_K2);
      6'd28: x = u(vkf_pkg::OP_MUL, R_P2, R_I1, R_T0);
      6'd29: x = u(vkf_pkg::OP_MUL, R_P3, R_I3, R_T1);
      6'd30: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_K3);
      6'd31: x = u(vkf_pkg::OP_SUB, R_Z0, R_V0, R_Y0);
      6'd32: x = u(vkf_pkg::OP_SUB, R_Z1, R_V1, R_Y1);
      6'd33: x = u(vkf_pkg::OP_MUL, R_K0, R_Y0, R_T0);
      6'd34: x = u(vkf_pkg::OP_MUL, R_K1, R_Y1, R_T1);
      6'd35: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd36: x = u(vkf_pkg::OP_ADD, R_V0, R_T0, R_V0);
      6'd37: x = u(vkf_pkg::OP_MUL, R_K2, R_Y0, R_T0);
      6'd38: x = u(vkf_pkg::OP_MUL, R_K3, R_Y1, R_T1);
      6'd39: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd40: x = u(vkf_pkg::OP_ADD, R_V1, R_T0, R_V1);
      6'd41: x = u(vkf_pkg::OP_MUL, R_K0, R_P0, R_T0);
      6'd42: x = u(vkf_pkg::OP_MUL, R_K1, R_P2, R_T1);
      6'd43: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd44: x = u(vkf_pkg::OP_SUB, R_P0, R_T0, R_N0);
      6'd45: x = u(vkf_pkg::OP_MUL, R_K0, R_P1, R_T0);
      6'd46: x = u(vkf_pkg::OP_MUL, R_K1, R_P3, R_T1);
      6'd47: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd48: x = u(vkf_pkg::OP_SUB, R_P1, R_T0, R_N1);
      6'd49: x = u(vkf_pkg::OP_MUL, R_K2, R_P0, R_T0);
      6'd50: x = u(vkf_pkg::OP_MUL, R_K3, R_P2, R_T1);
      6'd51: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd52: x = u(vkf_pkg::OP_SUB, R_P2, R_T0, R_P2);
      6'd53: x = u(vkf_pkg::OP_MUL, R_K2, R_P1, R_T0);
      6'd54: x = u(vkf_pkg::OP_MUL, R_K3, R_P3, R_T1);
      6'd55: x = u(vkf_pkg::OP_ADD, R_T0, R_T1, R_T0);
      6'd56: x = u(vkf_pkg::OP_SUB, R_P3, R_T0, R_P3);
      6'd57: x = u(vkf_pkg::OP_ADD, R_N0, R_ZERO, R_P0);
      default: x = u(vkf_pkg::OP_ADD, R_N1, R_ZERO, R_P1);
    endcase
    return x;
  endfunction

  function automatic logic signed [W-1:0] align(input logic [vkf_pkg::CfgWidth-1:0] v);
    logic [W+vkf_pkg::CfgWidth-1:0] e;
    logic [W+vkf_pkg::CfgWidth-1:0] m;
    if (FRAC_BITS >= 16) e = {{W{1'b0}}, v} << (FRAC_BITS - 16);
    else e = {{W{1'b0}}, v} >> (16 - FRAC_BITS);
    m = {{(vkf_pkg::CfgWidth+1){1'b0}}, {(W-1){1'b1}}};
    return (e > m) ? VMax : e[W-1:0];
  endfunction

  logic [15:0] dt_q;
  logic [31:0] qv_q, rv_q;
  logic signed [W-1:0] rf_q [NR];
  logic signed [W-1:0] rf_d [NR];
  logic pend_q, pend_d;
  logic upd_q, upd_d;
  vkf_pkg::state_e st_q, st_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic fused_q, fused_d, sing_q, sing_d;
  logic signed [W-1:0] vo0_q, vo1_q;
  vkf_pkg::alu_req_t req;
  uop_t uop;
  logic alu_done;
  logic signed [W-1:0] alu_res;
  logic in_acc, tick_acc, last;

  assign uop      = prog(pc_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign tick_acc = in_acc && s_axis_tuser;
  assign last     = upd_q ? (pc_q == PcW'(ProgLen)) : (pc_q == PcW'(PredLen));
  assign s_axis_tready = (st_q == vkf_pkg::ST_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      vkf_pkg::ST_IDLE: if (tick_acc) st_d = vkf_pkg::ST_RUN;
      vkf_pkg::ST_RUN:  st_d = vkf_pkg::ST_WAIT;
      vkf_pkg::ST_WAIT: begin
        if (alu_done) begin
          if (last || (pc_q == PcW'(DetPc) && alu_res == '0)) st_d = vkf_pkg::ST_OUT;
          else st_d = vkf_pkg::ST_RUN;
        end
      end
      default: if (m_axis_tready) st_d = vkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.start = (st_q == vkf_pkg::ST_RUN);
    req.op    = uop.op;
  end

  always_comb begin
    for (int i = 0; i < NR; i++) rf_d[i] = rf_q[i];
    pend_d = pend_q; upd_d = upd_q; pc_d = pc_q;
    fused_d = fused_q; sing_d = sing_q;
    rf_d[R_ZERO] = '0;
    rf_d[R_DT] = align({16'd0, dt_q});
    rf_d[R_QV] = align(qv_q);
    rf_d[R_R]  = align(rv_q);
    if (in_acc) begin
      if (s_axis_tuser) begin
        rf_d[R_A0] = s_axis_tdata[W-1:0];
        rf_d[R_A1] = s_axis_tdata[2*W-1:W];
        upd_d = pend_q; pend_d = 1'b0; pc_d = '0;
        fused_d = 1'b0; sing_d = 1'b0;
      end else begin
        rf_d[R_Z0] = s_axis_tdata[W-1:0];
        rf_d[R_Z1] = s_axis_tdata[2*W-1:W];
        pend_d = 1'b1;
      end
    end else if (st_q == vkf_pkg::ST_WAIT && alu_done) begin
      rf_d[uop.dst] = alu_res;
      pc_d = pc_q + 1'b1;
      if (pc_q == PcW'(DetPc) && alu_res == '0) sing_d = 1'b1;
      else if (last && upd_q) fused_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= vkf_pkg::ST_IDLE; pc_q <= '0; pend_q <= 1'b0; upd_q <= 1'b0;
      fused_q <= 1'b0; sing_q <= 1'b0;
      dt_q <= 16'd66; qv_q <= 32'd65536; rv_q <= 32'd65536;
      for (int i = 0; i < NR; i++) rf_q[i] <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; pend_q <= pend_d; upd_q <= upd_d;
      fused_q <= fused_d; sing_q <= sing_d;
      for (int i = 0; i < NR; i++) rf_q[i] <= rf_d[i];
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vkf_pkg::CFG_DELTA_TIME:     dt_q <= cfg_data_i[15:0];
          vkf_pkg::CFG_ACCEL_VARIANCE: qv_q <= cfg_data_i;
          vkf_pkg::CFG_ODOM_VARIANCE:  rv_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_d == vkf_pkg::ST_OUT && st_q != vkf_pkg::ST_OUT) begin
      vo0_q <= rf_d[R_V0]; vo1_q <= rf_d[R_V1];
    end
  end

  vkf_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (rf_q[uop.a]),
    .b_i    (rf_q[uop.b]),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign m_axis_tvalid = (st_q == vkf_pkg::ST_OUT);
  assign m_axis_tdata  = {vo1_q, vo0_q};
  assign m_axis_tuser  = {sing_q, fused_q};

  `VKF_ASSERT_IMP(a_excl_flags, clk_i, rst_ni, m_axis_tvalid, !(fused_q && sing_q),
    "fused and singular both set")
  `VKF_ASSERT_NEXT(a_tick_clears_pend, clk_i, rst_ni, tick_acc, !pend_q,
    "pending mark survived a tick")
  `VKF_ASSERT_IMP(a_no_done_idle, clk_i, rst_ni, st_q == vkf_pkg::ST_IDLE, !alu_done,
    "arithmetic result while idle")
  `VKF_ASSERT_IMP(a_fused_needs_upd, clk_i, rst_ni, m_axis_tvalid && fused_q, upd_q,
    "fused without a pending measurement")

endmodule

### verif/velocity_kalman_fusion_test.sv
// Self-checking testbench for the two-axis velocity Kalman fusion block
module velocity_kalman_fusion_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [vkf_pkg::CfgIdxWidth-1:0] CfgUnused = 2'd3;
  localparam logic ReqOdom = 1'b0;
  localparam logic ReqAccel = 1'b1;
  localparam int SettleCycles = 300;
  localparam longint CycleLimit = 4000000;
  localparam longint VelMax = 64'sd2147483647;
  localparam longint VelMin = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] vel_fb;
    logic signed [31:0] vel_lr;
    logic fused;
    logic singular;
  } estimate_t;

  class fusion_scoreboard;
    estimate_t estimates[$];
    longint vel[2];
    longint cov[4];
    longint meas[2];
    bit meas_pending;
    logic [15:0] delta_time;
    logic [31:0] accel_var;
    logic [31:0] odom_var;
    int errors;

    function new();
      vel = '{0, 0};
      cov = '{0, 0, 0, 0};
      meas = '{0, 0};
      meas_pending = 0;
      delta_time = 16'd66;
      accel_var = 32'd65536;
      odom_var = 32'd65536;
      errors = 0;
    endfunction

    function longint sat(longint a);
      if (a > VelMax) return VelMax;
      if (a < VelMin) return VelMin;
      return a;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = m >> 16;
      return sat((p < 0) ? -m : m);
    endfunction

    function longint qdiv(longint n, longint d);
      longint mn;
      longint md;
      longint q;
      if (d == 0) return 0;
      mn = ((n < 0) ? -n : n) << 16;
      md = (d < 0) ? -d : d;
      q = mn / md;
      return sat(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function void write_reg(logic [vkf_pkg::CfgIdxWidth-1:0] idx,
                            logic [vkf_pkg::CfgWidth-1:0] val);
      case (idx)
        vkf_pkg::CFG_DELTA_TIME: delta_time = val[15:0];
        vkf_pkg::CFG_ACCEL_VARIANCE: accel_var = val;
        vkf_pkg::CFG_ODOM_VARIANCE: odom_var = val;
        default: ;
      endcase
    endfunction

    function void note_input(logic req, logic signed [31:0] fb, logic signed [31:0] lr);
      longint dt, q, r, s00, s01, s10, s11, det, i00, i01, i10, i11, y0, y1;
      longint k[4];
      longint np[4];
      estimate_t e;
      if (req == ReqOdom) begin
        meas[0] = fb;
        meas[1] = lr;
        meas_pending = 1;
        return;
      end
      e.fused = 0;
      e.singular = 0;
      dt = delta_time;
      q = qmul(qmul(dt, dt), sat(longint'(accel_var)));
      r = sat(longint'(odom_var));
      vel[0] = sat(vel[0] + qmul(dt, fb));
      vel[1] = sat(vel[1] + qmul(dt, lr));
      cov[0] = sat(cov[0] + q);
      cov[3] = sat(cov[3] + q);
      if (meas_pending) begin
        meas_pending = 0;
        s00 = sat(cov[0] + r);
        s01 = cov[1];
        s10 = cov[2];
        s11 = sat(cov[3] + r);
        det = sat(qmul(s00, s11) - qmul(s01, s10));
        if (det == 0) begin
          e.singular = 1;
        end else begin
          i00 = qdiv(s11, det);
          i01 = qdiv(sat(-s01), det);
          i10 = qdiv(sat(-s10), det);
          i11 = qdiv(s00, det);
          k[0] = sat(qmul(cov[0], i00) + qmul(cov[1], i10));
          k[1] = sat(qmul(cov[0], i01) + qmul(cov[1], i11));
          k[2] = sat(qmul(cov[2], i00) + qmul(cov[3], i10));
          k[3] = sat(qmul(cov[2], i01) + qmul(cov[3], i11));
          y0 = sat(meas[0] - vel[0]);
          y1 = sat(meas[1] - vel[1]);
          vel[0] = sat(vel[0] + sat(qmul(k[0], y0) + qmul(k[1], y1)));
          vel[1] = sat(vel[1] + sat(qmul(k[2], y0) + qmul(k[3], y1)));
          for (int i = 0; i < 4; i++) begin
            np[i] = sat(cov[i] - sat(qmul(k[(i >> 1) * 2], cov[i & 1]) +
                                     qmul(k[(i >> 1) * 2 + 1], cov[2 + (i & 1)])));
          end
          cov = np;
          e.fused = 1;
        end
      end
      e.vel_fb = vel[0][31:0];
      e.vel_lr = vel[1][31:0];
      estimates.push_back(e);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_estimate(logic [63:0] data, logic [1:0] flags);
      estimate_t e;
      if (estimates.size() == 0) begin
        report($sformatf("unexpected estimate data=%h flags=%b", data, flags));
        return;
      end
      e = estimates.pop_front();
      if (data[31:0] !== e.vel_fb)
        report($sformatf("vel_fb got %h exp %h", data[31:0], e.vel_fb));
      if (data[63:32] !== e.vel_lr)
        report($sformatf("vel_lr got %h exp %h", data[63:32], e.vel_lr));
      if (flags[0] !== e.fused)
        report($sformatf("fused got %b exp %b", flags[0], e.fused));
      if (flags[1] !== e.singular)
        report($sformatf("singular got %b exp %b", flags[1], e.singular));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 0;
  logic [vkf_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [vkf_pkg::CfgWidth-1:0] cfg_data_i = '0;

  fusion_scoreboard sb = new();
  bit steady;
  longint cycles = 0;

  velocity_kalman_fusion dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $signed($urandom) >>> $urandom_range(6, 26);
    endcase
  endfunction

  task automatic send(logic req, logic signed [31:0] fb, logic signed [31:0] lr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {lr, fb};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(req, fb, lr);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.estimates.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] dt, logic [31:0] av, logic [31:0] ov, bit stray);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= vkf_pkg::CFG_DELTA_TIME;
    cfg_data_i <= {16'($urandom_range(0, 65535)), dt};
    @(posedge clk_i);
    sb.write_reg(vkf_pkg::CFG_DELTA_TIME, {16'h0, dt});
    cfg_idx_i <= vkf_pkg::CFG_ACCEL_VARIANCE;
    cfg_data_i <= av;
    @(posedge clk_i);
    sb.write_reg(vkf_pkg::CFG_ACCEL_VARIANCE, av);
    cfg_idx_i <= vkf_pkg::CFG_ODOM_VARIANCE;
    cfg_data_i <= ov;
    @(posedge clk_i);
    sb.write_reg(vkf_pkg::CFG_ODOM_VARIANCE, ov);
    if (stray) begin
      cfg_idx_i <= CfgUnused;
      cfg_data_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        send(ReqOdom, pick_value(), pick_value());
        if ($urandom_range(0, 4) == 0) send(ReqOdom, pick_value(), pick_value());
        send(ReqAccel, pick_value(), pick_value());
        i++;
      end else begin
        send($urandom_range(0, 3) != 0 ? ReqAccel : ReqOdom, pick_value(), pick_value());
      end
    end
    settle();
  endtask

  initial begin
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_estimate(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    steady = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero covariance and zero odometry noise: singular innovation
    configure(16'd66, 32'd0, 32'd0, 1'b1);
    send(ReqAccel, 32'sd65536, -32'sd65536);
    send(ReqOdom, 32'sd100000, 32'sd5);
    send(ReqAccel, 32'sd0, 32'sd0);
    send(ReqAccel, 32'sd0, 32'sd0);
    settle();

    configure(16'd66, 32'd65536, 32'd65536, 1'b0);
    send(ReqOdom, 32'h7fff_ffff, 32'h8000_0000);
    send(ReqOdom, 32'sd131072, -32'sd131072);
    send(ReqAccel, 32'h7fff_ffff, 32'h8000_0000);
    send(ReqAccel, 32'h8000_0000, 32'h7fff_ffff);
    send(ReqOdom, 32'h8000_0000, 32'h7fff_ffff);
    send(ReqAccel, 32'hffff_ffff, 32'h0);
    send(ReqOdom, 32'sd0, 32'sd0);
    send(ReqAccel, 32'sd65536, 32'sd65536);
    settle();

    configure(16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send(ReqAccel, 32'h7fff_ffff, 32'h7fff_ffff);
    send(ReqOdom, 32'h8000_0000, 32'h8000_0000);
    send(ReqAccel, 32'h8000_0000, 32'h8000_0000);
    send(ReqOdom, 32'sd12345, -32'sd12345);
    send(ReqAccel, 32'sd0, 32'sd0);
    settle();

    configure(16'd0, 32'd0, 32'd65536, 1'b0);
    send(ReqOdom, 32'sd300000, -32'sd300000);
    send(ReqAccel, 32'h7fff_ffff, 32'h8000_0000);
    settle();

    random_phase(250);
    configure(16'hffff, 32'd65536, 32'd0, 1'b1);
    random_phase(200);
    configure(16'd0, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    random_phase(200);
    configure(16'd66, 32'd65536, 32'd65536, 1'b0);
    random_phase(300);
    for (int p = 0; p < 4; p++) begin
      configure(16'($urandom_range(0, 65535)), $urandom >> $urandom_range(0, 24),
                $urandom >> $urandom_range(0, 24), p == 0);
      random_phase(225);
    end

    settle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
